// ===== hw/rtl/ilid_pkg.sv =====
// Shared types, constants and controller/datapath interface for the indexed list.
package ilid_pkg;

   localparam int ILID_CAPACITY = 64;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 7;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [KIND_W-1:0] {
      REQ_APPEND = 3'd0,
      REQ_INSERT = 3'd1,
      REQ_READ   = 3'd2,
      REQ_MODIFY = 3'd3,
      REQ_DELETE = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } rsp_status_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_CUR_DEC,
      RD_CUR_INC
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_COUNT_VAL,
      WR_POS_VAL,
      WR_CUR_DATA
   } wr_sel_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_FROM_COUNT,
      CUR_FROM_POS,
      CUR_DEC,
      CUR_INC
   } cur_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_UP_RD,
      S_UP_WR,
      S_PUT,
      S_DN_RD,
      S_DN_WR,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic           req_load;
      logic           set_status;
      rsp_status_type status;
      logic           mem_rd;
      rd_sel_type     rd_sel;
      logic           mem_wr;
      wr_sel_type     wr_sel;
      cur_op_type     cur_op;
      logic           count_inc;
      logic           count_dec;
      logic           rsp_load;
   } ilid_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              pos_gt_count;
      logic              pos_ge_count;
      logic              cur_at_pos;
      logic              cur_next_lt_count;
      logic              rsp_free;
   } ilid_stat_type;

endpackage

// ===== hw/rtl/ilid_ctrl.sv =====
// Controller state machine that sequences each list transaction through the datapath.
module ilid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ilid_pkg::ilid_stat_type stat,
   output ilid_pkg::ilid_cmd_type  cmd
);
   import ilid_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.kind)
               REQ_INSERT: begin
                  if (!stat.full && !stat.pos_gt_count) state_in = S_UP_RD;
                  else state_in = S_DONE;
               end
               REQ_DELETE: begin
                  if (!stat.pos_ge_count) state_in = S_DN_RD;
                  else state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_UP_RD: begin
            if (stat.cur_at_pos) state_in = S_PUT;
            else state_in = S_UP_WR;
         end
         S_UP_WR: state_in = S_UP_RD;
         S_PUT:   state_in = S_DONE;
         S_DN_RD: begin
            if (stat.cur_next_lt_count) state_in = S_DN_WR;
            else state_in = S_DONE;
         end
         S_DN_WR: state_in = S_DN_RD;
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = ST_DONE;
      cmd.rd_sel = RD_POS;
      cmd.wr_sel = WR_POS_VAL;
      cmd.cur_op = CUR_HOLD;
      req_stall  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.req_load = req_valid;
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            unique case (stat.kind)
               REQ_APPEND: begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.mem_wr    = 1'b1;
                     cmd.wr_sel    = WR_COUNT_VAL;
                     cmd.count_inc = 1'b1;
                  end
               end
               REQ_INSERT: begin
                  // The full check takes precedence over the index check.
                  if (stat.full) cmd.status = ST_FULL;
                  else if (stat.pos_gt_count) cmd.status = ST_RANGE;
                  else cmd.cur_op = CUR_FROM_COUNT;
               end
               REQ_READ: begin
                  if (stat.pos_ge_count) begin
                     cmd.status = ST_RANGE;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.rd_sel = RD_POS;
                  end
               end
               REQ_MODIFY: begin
                  if (stat.pos_ge_count) begin
                     cmd.status = ST_RANGE;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wr_sel = WR_POS_VAL;
                  end
               end
               REQ_DELETE: begin
                  if (stat.pos_ge_count) cmd.status = ST_RANGE;
                  else cmd.cur_op = CUR_FROM_POS;
               end
               default: cmd.status = ST_DONE;
            endcase
         end
         S_UP_RD: begin
            if (!stat.cur_at_pos) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_CUR_DEC;
            end
         end
         S_UP_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_CUR_DATA;
            cmd.cur_op = CUR_DEC;
         end
         S_PUT: begin
            cmd.mem_wr    = 1'b1;
            cmd.wr_sel    = WR_POS_VAL;
            cmd.count_inc = 1'b1;
         end
         S_DN_RD: begin
            if (stat.cur_next_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_CUR_INC;
            end else begin
               cmd.count_dec = 1'b1;
            end
         end
         S_DN_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_CUR_DATA;
            cmd.cur_op = CUR_INC;
         end
         S_DONE: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ilid_datapath.sv =====
// Datapath: entry memory, count, shift cursor, request registers and result register.
module ilid_datapath #(
   parameter int CAPACITY = ilid_pkg::ILID_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ilid_pkg::KIND_W-1:0]   req_type,
   input  logic [ilid_pkg::POS_W-1:0]    req_position,
   input  logic [ilid_pkg::DATA_W-1:0]   req_data_value,
   input  ilid_pkg::ilid_cmd_type        cmd,
   output ilid_pkg::ilid_stat_type       stat,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ilid_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [ilid_pkg::POS_W-1:0]    rsp_entry_count,
   output logic [ilid_pkg::STATUS_W-1:0] rsp_status
);
   import ilid_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;

   logic [KIND_W-1:0] kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [ADDR_W-1:0] cursor_ff;
   logic [ADDR_W-1:0] cursor_in;
   rsp_status_type    status_ff;
   rsp_status_type    status_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff;
   logic [DATA_W-1:0]   rsp_value_in;
   logic [POS_W-1:0]    rsp_count_ff;
   logic [POS_W-1:0]    rsp_count_in;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  cursor_ext;
   logic [CMP_W-1:0]  cursor_next_ext;
   logic [ADDR_W-1:0] pos_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   assign pos_ext         = CMP_W'(pos_ff);
   assign count_ext       = CMP_W'(count_ff);
   assign cursor_ext      = CMP_W'(cursor_ff);
   assign cursor_next_ext = cursor_ext + CMP_W'(1);
   // Only used once the index is known to lie within the list: below the count, or at most the count for an insert.
   assign pos_addr        = pos_ext[ADDR_W-1:0];

   assign stat.kind              = kind_ff;
   assign stat.full              = (count_ff == CNT_W'(CAPACITY));
   assign stat.pos_gt_count      = (pos_ext > count_ext);
   assign stat.pos_ge_count      = (pos_ext >= count_ext);
   assign stat.cur_at_pos        = (cursor_ext == pos_ext);
   assign stat.cur_next_lt_count = (cursor_next_ext < count_ext);
   assign stat.rsp_free          = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_POS:     rd_addr = pos_addr;
         RD_CUR_DEC: rd_addr = cursor_ff - ADDR_W'(1);
         RD_CUR_INC: rd_addr = cursor_ff + ADDR_W'(1);
         default:    rd_addr = pos_addr;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_COUNT_VAL: begin
            wr_addr = count_ext[ADDR_W-1:0];
            wr_data = val_ff;
         end
         WR_POS_VAL: begin
            wr_addr = pos_addr;
            wr_data = val_ff;
         end
         WR_CUR_DATA: begin
            wr_addr = cursor_ff;
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = pos_addr;
            wr_data = val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         kind_ff <= req_type;
         pos_ff  <= req_position;
         val_ff  <= req_data_value;
      end
   end

   always_comb begin
      unique case (cmd.cur_op)
         CUR_HOLD:       cursor_in = cursor_ff;
         CUR_FROM_COUNT: cursor_in = count_ext[ADDR_W-1:0];
         CUR_FROM_POS:   cursor_in = pos_addr;
         CUR_DEC:        cursor_in = cursor_ff - ADDR_W'(1);
         CUR_INC:        cursor_in = cursor_ff + ADDR_W'(1);
         default:        cursor_in = cursor_ff;
      endcase
   end

   always_comb begin
      priority if (cmd.count_inc) count_in = count_ff + CNT_W'(1);
      else if (cmd.count_dec) count_in = count_ff - CNT_W'(1);
      else count_in = count_ff;
   end

   assign status_in = cmd.set_status ? cmd.status : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         status_ff <= ST_DONE;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         status_ff <= status_in;
      end
   end

   assign rsp_value_in = (kind_ff == REQ_READ && status_ff == ST_DONE) ? rdata_ff : '0;
   assign rsp_count_in = count_ext[POS_W-1:0];

   always_comb begin
      priority if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Top level of the indexed list: a packed list of signed 32-bit entries with a count.
// Usage: a request transaction on req_* carries a kind (append, insert, read, modify,
// delete), an entry position and a data value. Each request gives exactly one response
// transaction on rsp_* with the value read (zero unless a read succeeded), the entry
// count after the request, and a status (done, full, or index out of range).
// The block takes one request at a time; req_stall is low only while it is idle.
// A request passes from idle to an execute state, then to a done state that loads the
// response register; append, read, modify, rejected and unknown requests take no other
// states. Insert and delete first shift entries one at a time through the entry memory,
// each move a read state and then a write state; insert then writes the new entry.
// The block returns to idle, ready for the next request, in the same cycle in which
// rsp_valid rises.
// The response sits in an output register, so the next request can be accepted while
// the receiver stalls; that request then waits for the register before it completes.
// Reset clears the count, so the list is empty; entry contents are not cleared.
module indexed_list_insert_delete #(
   parameter int CAPACITY = ilid_pkg::ILID_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ilid_pkg::KIND_W-1:0]          req_type,
   input  logic [ilid_pkg::POS_W-1:0]           req_position,
   input  logic signed [ilid_pkg::DATA_W-1:0]   req_data_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ilid_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [ilid_pkg::POS_W-1:0]           rsp_entry_count,
   output logic [ilid_pkg::STATUS_W-1:0]        rsp_status
);
   import ilid_pkg::*;

   ilid_cmd_type  cmd;
   ilid_stat_type stat;

   ilid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ilid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_data_value  (req_data_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== hw/rtl/ilid_checker.sv =====
// Port-level checker for the indexed list, bound to the top level.
module ilid_checker #(
   parameter int CAPACITY = ilid_pkg::ILID_CAPACITY
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [ilid_pkg::DATA_W-1:0]   rsp_read_value,
   input logic [ilid_pkg::POS_W-1:0]           rsp_entry_count,
   input logic [ilid_pkg::STATUS_W-1:0]        rsp_status
);
   import ilid_pkg::*;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("response changed while stalled");

   // A rejected request never reports a value.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_read_value == '0)
      else $error("rejected request returned a nonzero value");

   // The reported count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_entry_count) <= CAPACITY)
      else $error("entry count above capacity");

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // While the block is busy it refuses new requests.
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a transaction was in progress");

endmodule

bind indexed_list_insert_delete ilid_checker #(
   .CAPACITY (CAPACITY)
) u_ilid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_read_value  (rsp_read_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_status      (rsp_status)
);
